/* sv/bcn_pkg.sv */
// Shared types and constants for the bounding-box coordinate normaliser.
`default_nettype none

package bcn_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int LEN_BITS  = 32;
  localparam int CRD_W     = FRAC_BITS + 1;
  localparam int HI_W      = LEN_BITS - FRAC_BITS;
  localparam int MULA_W    = (HI_W > FRAC_BITS) ? HI_W : FRAC_BITS;
  localparam int CNT_W     = $clog2(FRAC_BITS);

  localparam logic [CRD_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Request codes
  localparam logic [1:0] REQ_BEGIN   = 2'd0;
  localparam logic [1:0] REQ_MEASURE = 2'd1;
  localparam logic [1:0] REQ_FINISH  = 2'd2;
  localparam logic [1:0] REQ_NORM    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LEN_A = 2'd0;
  localparam logic [1:0] CFG_LEN_B = 2'd1;
  localparam logic [1:0] CFG_LEN_C = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
    logic [CRD_W-1:0] coord_z;
    logic             included;
  } bcn_in_t;

  typedef struct packed {
    logic [CRD_W-1:0]    norm_x;
    logic [CRD_W-1:0]    norm_y;
    logic [CRD_W-1:0]    norm_z;
    logic [LEN_BITS-1:0] scaled_a;
    logic [LEN_BITS-1:0] scaled_b;
    logic [LEN_BITS-1:0] scaled_c;
    logic                degenerate;
    logic                empty_set;
  } bcn_out_t;

  // Clamp a coordinate to 1.0
  function automatic logic [CRD_W-1:0] sat_coord(input logic [CRD_W-1:0] v);
    return (v > ONE) ? ONE : v;
  endfunction

endpackage

`default_nettype wire

/* sv/bbox_coordinate_normalizer.sv */
// Top level: bounding-box measurement, extent scaling and coordinate normalisation.
`default_nettype none

// Begin and measure transfers complete in the cycle they are accepted and give no
// result. A finish makes six passes through one 16x17 multiplier (high and low
// half of each cell length times its extent) before the hand-over; a finish with
// no included atom measured skips the multiplier and goes straight to hand-over.
// A normalise of an included atom has, per axis, one set-up state and 16 steps
// of one shared restoring divider, reused for x, y and z; an axis with zero
// extent, at or below the minimum or saturating skips its division. Excluded
// atoms go straight to hand-over. in_stall is high while an item is in progress
// and while a finished result waits for the output register to free up.
module bbox_coordinate_normalizer (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  bcn_pkg::bcn_in_t                  in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output bcn_pkg::bcn_out_t                 out_data,
  input  wire                               cfg_we,
  input  wire  [1:0]                        cfg_idx,
  input  wire  [bcn_pkg::LEN_BITS-1:0]      cfg_wdata
);
  import bcn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

  // Control and architectural state
  state_t              state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LEN_BITS-1:0] len_r [3];
  logic [LEN_BITS-1:0] len_nxt [3];
  logic [CRD_W-1:0]    min_r [3];
  logic [CRD_W-1:0]    min_nxt [3];
  logic [CRD_W-1:0]    max_r [3];
  logic [CRD_W-1:0]    max_nxt [3];
  logic [CRD_W-1:0]    ext_r [3];
  logic [CRD_W-1:0]    ext_nxt [3];
  logic                seen_r, seen_nxt;

  // Working registers
  logic [1:0]           ax_r, ax_nxt;
  logic                 part_r, part_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FRAC_BITS-1:0] rem_r, rem_nxt;
  logic [FRAC_BITS-2:0] quo_r, quo_nxt;
  logic [LEN_BITS-1:0]  acc_r, acc_nxt;
  logic [CRD_W-1:0]     crd_r [3];
  logic [CRD_W-1:0]     crd_nxt [3];
  logic [CRD_W-1:0]     rnorm_r [3];
  logic [CRD_W-1:0]     rnorm_nxt [3];
  logic [LEN_BITS-1:0]  rscl_r [3];
  logic [LEN_BITS-1:0]  rscl_nxt [3];
  logic                 rempty_r, rempty_nxt;
  bcn_out_t             out_r, out_nxt;

  // Input side
  logic                 in_take;
  logic [CRD_W-1:0]     in_crd [3];

  // Shared unit operands
  logic [CRD_W-1:0]         sel_v, sel_lo, sel_ext;
  logic [CRD_W-1:0]         diff;
  logic [CRD_W-1:0]         div_sh;
  logic                     div_ge;
  logic [MULA_W-1:0]        mul_a;
  logic [MULA_W+CRD_W-1:0]  mul_p;
  logic                     out_free;
  logic                     degen;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign in_crd[0] = sat_coord(in_data.coord_x);
  assign in_crd[1] = sat_coord(in_data.coord_y);
  assign in_crd[2] = sat_coord(in_data.coord_z);

  // Axis operand selection for the divider and the multiplier
  assign sel_v   = crd_r[ax_r];
  assign sel_lo  = min_r[ax_r];
  assign sel_ext = ext_r[ax_r];
  assign diff    = sel_v - sel_lo;
  assign div_sh  = {rem_r, 1'b0};
  assign div_ge  = (div_sh >= sel_ext);
  assign mul_a   = part_r ? MULA_W'(len_r[ax_r][FRAC_BITS-1:0])
                          : MULA_W'(len_r[ax_r][LEN_BITS-1:FRAC_BITS]);
  assign mul_p   = mul_a * sel_ext;
  assign degen   = (ext_r[0] == '0) || (ext_r[1] == '0) || (ext_r[2] == '0);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    seen_nxt      = seen_r;
    ax_nxt        = ax_r;
    part_nxt      = part_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    acc_nxt       = acc_r;
    rempty_nxt    = rempty_r;
    out_nxt       = out_r;
    for (int i = 0; i < 3; i++) begin
      len_nxt[i]   = len_r[i];
      min_nxt[i]   = min_r[i];
      max_nxt[i]   = max_r[i];
      ext_nxt[i]   = ext_r[i];
      crd_nxt[i]   = crd_r[i];
      rnorm_nxt[i] = rnorm_r[i];
      rscl_nxt[i]  = rscl_r[i];
    end

    // Configuration writes
    if (cfg_we) begin
      case (cfg_idx)
        CFG_LEN_A: len_nxt[0] = cfg_wdata;
        CFG_LEN_B: len_nxt[1] = cfg_wdata;
        CFG_LEN_C: len_nxt[2] = cfg_wdata;
        default:   ;
      endcase
    end

    // Output register drains on transfer
    if (!out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          ax_nxt   = '0;
          part_nxt = 1'b0;
          case (in_data.req_type)
            REQ_BEGIN: begin
              for (int i = 0; i < 3; i++) begin
                min_nxt[i] = ONE;
                max_nxt[i] = '0;
              end
              seen_nxt = 1'b0;
            end
            REQ_MEASURE: begin
              if (in_data.included) begin
                for (int i = 0; i < 3; i++) begin
                  if (in_crd[i] > max_r[i]) max_nxt[i] = in_crd[i];
                  if (in_crd[i] < min_r[i]) min_nxt[i] = in_crd[i];
                end
                seen_nxt = 1'b1;
              end
            end
            REQ_FINISH: begin
              for (int i = 0; i < 3; i++) begin
                rnorm_nxt[i] = '0;
                ext_nxt[i]   = (seen_r && max_r[i] > min_r[i]) ? max_r[i] - min_r[i] : '0;
                rscl_nxt[i]  = len_r[i];
              end
              rempty_nxt = !seen_r;
              state_nxt  = seen_r ? S_MUL : S_PUT;
            end
            REQ_NORM: begin
              for (int i = 0; i < 3; i++) begin
                crd_nxt[i]   = in_crd[i];
                rnorm_nxt[i] = in_crd[i];
                rscl_nxt[i]  = '0;
              end
              rempty_nxt = 1'b0;
              state_nxt  = in_data.included ? S_PREP : S_PUT;
            end
            default: ;
          endcase
        end
      end

      // Per-axis set-up: trivial cases skip the divider
      S_PREP: begin
        if (sel_ext == '0 || sel_v <= sel_lo) begin
          rnorm_nxt[ax_r] = '0;
        end else if (diff >= sel_ext) begin
          rnorm_nxt[ax_r] = ONE;
        end else begin
          rem_nxt   = diff[FRAC_BITS-1:0];
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
        if (state_nxt == S_PREP) begin
          if (ax_r == 2'd2) state_nxt = S_PUT;
          else              ax_nxt    = ax_r + 2'd1;
        end
      end

      // One restoring division step per cycle
      S_DIV: begin
        rem_nxt = div_ge ? FRAC_BITS'(div_sh - sel_ext) : div_sh[FRAC_BITS-1:0];
        quo_nxt = {quo_r[FRAC_BITS-3:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          rnorm_nxt[ax_r] = {1'b0, quo_r, div_ge};
          if (ax_r == 2'd2) begin
            state_nxt = S_PUT;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = S_PREP;
          end
        end
      end

      // Length scaling: high half product, then low half product added in
      S_MUL: begin
        if (!part_r) begin
          acc_nxt  = LEN_BITS'(mul_p);
          part_nxt = 1'b1;
        end else begin
          rscl_nxt[ax_r] = acc_r + LEN_BITS'(mul_p >> FRAC_BITS);
          part_nxt       = 1'b0;
          if (ax_r == 2'd2) state_nxt = S_PUT;
          else              ax_nxt    = ax_r + 2'd1;
        end
      end

      // Hand the result to the output register
      S_PUT: begin
        if (out_free) begin
          out_nxt.norm_x     = rnorm_r[0];
          out_nxt.norm_y     = rnorm_r[1];
          out_nxt.norm_z     = rnorm_r[2];
          out_nxt.scaled_a   = rscl_r[0];
          out_nxt.scaled_b   = rscl_r[1];
          out_nxt.scaled_c   = rscl_r[2];
          out_nxt.degenerate = degen;
          out_nxt.empty_set  = rempty_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state and bounds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        len_r[i] <= LEN_BITS'(ONE);
        min_r[i] <= ONE;
        max_r[i] <= '0;
        ext_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seen_r      <= seen_nxt;
      for (int i = 0; i < 3; i++) begin
        len_r[i] <= len_nxt[i];
        min_r[i] <= min_nxt[i];
        max_r[i] <= max_nxt[i];
        ext_r[i] <= ext_nxt[i];
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    ax_r     <= ax_nxt;
    part_r   <= part_nxt;
    cnt_r    <= cnt_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    acc_r    <= acc_nxt;
    rempty_r <= rempty_nxt;
    out_r    <= out_nxt;
    for (int i = 0; i < 3; i++) begin
      crd_r[i]   <= crd_nxt[i];
      rnorm_r[i] <= rnorm_nxt[i];
      rscl_r[i]  <= rscl_nxt[i];
    end
  end

`ifndef SYNTHESIS
  // Divider remainder always stays below the divisor
  a_rem_below_ext: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> ({1'b0, rem_r} < sel_ext))
    else $error("divider remainder not below extent");

  // Normalised coordinates never exceed 1.0
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.norm_x <= ONE && out_r.norm_y <= ONE && out_r.norm_z <= ONE))
    else $error("normalised coordinate above 1.0");

  // An empty finish always reports degenerate extents
  a_empty_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.empty_set) |-> out_r.degenerate)
    else $error("empty set without degenerate flag");

  // A new result appears only after the hand-over state
  a_load_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUT))
    else $error("result loaded outside hand-over");
`endif

endmodule

`default_nettype wire

/* bench/tb_bbox_coordinate_normalizer.sv */
// Self-checking bench for the bounding-box coordinate normaliser: directed rows, random passes.
module tb_bbox_coordinate_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  import bcn_pkg::*;

  localparam int UNIT       = 1 << FRAC_BITS;
  localparam int CRD_MAX    = (1 << CRD_W) - 1;
  localparam int RAND_ITEMS = 950;
  localparam int SETTLE_CYC = 64;

  // Clock, reset and block ports
  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  bcn_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  bcn_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [1:0]          cfg_idx   = CFG_LEN_A;
  logic [LEN_BITS-1:0] cfg_wdata = '0;

  bbox_coordinate_normalizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block's bounds, latched extents and cell lengths
  logic [CRD_W-1:0]    bnd_min [3];
  logic [CRD_W-1:0]    bnd_max [3];
  logic [CRD_W-1:0]    ext_lat [3];
  bit                  seen_atom;
  logic [LEN_BITS-1:0] cell_len [3];

  // Results owed by the block, oldest first
  bcn_out_t crop_results_due [$];
  bcn_out_t want_res;

  typedef struct {
    bcn_in_t  item;
    bit       typed;
    bcn_out_t res;
  } dir_row_t;

  dir_row_t dir_rows [$];

  int errors          = 0;
  int results_checked = 0;
  int work_items      = 0;
  int finishes_sent   = 0;
  int norms_sent      = 0;
  int len_settings    = 0;
  int burst_left      = 0;
  int stall_mode      = 0;
  int mode_left       = 0;
  int stall_tick      = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #24_000_000;
    $display("Timeout: transfers stopped completing");
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned exp_val);
    errors++;
    $display("%0t ns  mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
  endtask

  // Q16.16 length times Q1.16 extent, truncated, wrapped to the length width
  function automatic logic [LEN_BITS-1:0] scaled_extent(input logic [LEN_BITS-1:0] len,
                                                        input logic [CRD_W-1:0] ext);
    longint unsigned hi;
    longint unsigned lo;
    hi = len >> FRAC_BITS;
    lo = len & (UNIT - 1);
    return LEN_BITS'(hi * ext + ((lo * ext) >> FRAC_BITS));
  endfunction

  // (v - lo) / ext in Q1.16, zero at or below the minimum, clamped to 1.0
  function automatic logic [CRD_W-1:0] axis_fraction(input logic [CRD_W-1:0] v,
                                                     input logic [CRD_W-1:0] lo,
                                                     input logic [CRD_W-1:0] ext);
    longint unsigned q;
    if (ext == 0 || v <= lo) return '0;
    q = (longint'(v - lo) << FRAC_BITS) / ext;
    return (q > UNIT) ? CRD_W'(UNIT) : CRD_W'(q);
  endfunction

  function automatic logic [CRD_W-1:0] clamp_unit(input logic [CRD_W-1:0] v);
    return (v > UNIT) ? CRD_W'(UNIT) : v;
  endfunction

  // Advance the shadow by one accepted item and work out its result, if any
  task automatic crop_and_scale(input bcn_in_t it, output bit gives, output bcn_out_t r);
    logic [CRD_W-1:0] c [3];
    c[0]  = clamp_unit(it.coord_x);
    c[1]  = clamp_unit(it.coord_y);
    c[2]  = clamp_unit(it.coord_z);
    r     = '0;
    gives = 1'b0;
    case (it.req_type)
      REQ_BEGIN: begin
        for (int a = 0; a < 3; a++) begin
          bnd_min[a] = CRD_W'(UNIT);
          bnd_max[a] = '0;
        end
        seen_atom = 1'b0;
      end
      REQ_MEASURE: begin
        if (it.included) begin
          for (int a = 0; a < 3; a++) begin
            if (c[a] > bnd_max[a]) bnd_max[a] = c[a];
            if (c[a] < bnd_min[a]) bnd_min[a] = c[a];
          end
          seen_atom = 1'b1;
        end
      end
      REQ_FINISH: begin
        gives = 1'b1;
        for (int a = 0; a < 3; a++)
          ext_lat[a] = (seen_atom && bnd_max[a] > bnd_min[a]) ? bnd_max[a] - bnd_min[a] : '0;
        if (seen_atom) begin
          r.scaled_a = scaled_extent(cell_len[0], ext_lat[0]);
          r.scaled_b = scaled_extent(cell_len[1], ext_lat[1]);
          r.scaled_c = scaled_extent(cell_len[2], ext_lat[2]);
        end else begin
          // nothing measured: lengths come back unscaled
          r.scaled_a  = cell_len[0];
          r.scaled_b  = cell_len[1];
          r.scaled_c  = cell_len[2];
          r.empty_set = 1'b1;
        end
      end
      default: begin
        gives = 1'b1;
        if (it.included) begin
          r.norm_x = axis_fraction(c[0], bnd_min[0], ext_lat[0]);
          r.norm_y = axis_fraction(c[1], bnd_min[1], ext_lat[1]);
          r.norm_z = axis_fraction(c[2], bnd_min[2], ext_lat[2]);
        end else begin
          r.norm_x = c[0];
          r.norm_y = c[1];
          r.norm_z = c[2];
        end
      end
    endcase
    if (gives)
      r.degenerate = (ext_lat[0] == 0) || (ext_lat[1] == 0) || (ext_lat[2] == 0);
  endtask

  function automatic bcn_in_t mk_in(input logic [1:0] req, input int x, input int y,
                                    input int z, input bit inc);
    bcn_in_t it;
    it.req_type = req;
    it.coord_x  = CRD_W'(x);
    it.coord_y  = CRD_W'(y);
    it.coord_z  = CRD_W'(z);
    it.included = inc;
    return it;
  endfunction

  function automatic bcn_out_t mk_res(input int nx, input int ny, input int nz,
                                      input longint sa, input longint sb, input longint sc,
                                      input bit deg, input bit emp);
    bcn_out_t r;
    r.norm_x     = CRD_W'(nx);
    r.norm_y     = CRD_W'(ny);
    r.norm_z     = CRD_W'(nz);
    r.scaled_a   = LEN_BITS'(sa);
    r.scaled_b   = LEN_BITS'(sb);
    r.scaled_c   = LEN_BITS'(sc);
    r.degenerate = deg;
    r.empty_set  = emp;
    return r;
  endfunction

  // Sender rhythm: bursts of back-to-back transfers separated by gaps
  task automatic sender_pace();
    int sel;
    burst_left--;
    if (burst_left > 0) return;
    in_valid <= 1'b0;
    sel = $urandom_range(0, 99);
    if (sel < 55)      repeat ($urandom_range(1, 3))  @(posedge clk);
    else if (sel < 85) repeat ($urandom_range(4, 20)) @(posedge clk);
    else               repeat ($urandom_range(21, 70)) @(posedge clk);
    burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
  endtask

  // Offer one item, wait for the transfer, log what it should produce
  task automatic send_item(input bcn_in_t it, input bit typed, input bcn_out_t typed_res);
    bit       gives;
    bcn_out_t pred;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    crop_and_scale(it, gives, pred);
    if (gives) crop_results_due.push_back(typed ? typed_res : pred);
    if (!(it.req_type == REQ_MEASURE && !it.included)) work_items++;
    if (it.req_type == REQ_FINISH) finishes_sent++;
    if (it.req_type == REQ_NORM)   norms_sent++;
    sender_pace();
  endtask

  task automatic send_plain(input bcn_in_t it);
    send_item(it, 1'b0, '0);
  endtask

  // Quiet the sender and let every owed result and any trailing work drain
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (crop_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic program_lengths(input logic [LEN_BITS-1:0] la, input logic [LEN_BITS-1:0] lb,
                                 input logic [LEN_BITS-1:0] lc);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LEN_A;
    cfg_wdata <= la;
    @(posedge clk);
    cfg_idx   <= CFG_LEN_B;
    cfg_wdata <= lb;
    @(posedge clk);
    cfg_idx   <= CFG_LEN_C;
    cfg_wdata <= lc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cell_len[0] = la;
    cell_len[1] = lb;
    cell_len[2] = lc;
    len_settings++;
  endtask

  function automatic logic [LEN_BITS-1:0] pick_length();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return LEN_BITS'($urandom);
    if (sel < 7) return LEN_BITS'($urandom_range(0, 4 * UNIT));
    if (sel < 8) return '1;
    if (sel < 9) return '0;
    return LEN_BITS'(UNIT);
  endfunction

  // Anywhere in the field, with weight on 0, 1.0 and values past 1.0
  function automatic int any_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8)  return 0;
    if (sel < 16) return UNIT;
    if (sel < 24) return $urandom_range(CRD_MAX, UNIT + 1);
    if (sel < 27) return CRD_MAX;
    return $urandom_range(UNIT - 1, 0);
  endfunction

  function automatic int window_coord(input int base, input int span);
    int v;
    if ($urandom_range(0, 9) == 0) return any_coord();
    v = base + $urandom_range(span, 0);
    return (v > CRD_MAX) ? CRD_MAX : v;
  endfunction

  // Normalise coordinate: mostly inside the measured box, sometimes just outside
  function automatic int norm_coord(input int axis);
    int lo;
    int hi;
    int sel;
    lo  = bnd_min[axis];
    hi  = bnd_max[axis];
    sel = $urandom_range(0, 99);
    if (hi < lo || sel >= 85) return any_coord();
    if (sel < 70) return $urandom_range(hi, lo);
    if (sel < 78) return (lo > 0) ? lo - 1 : 0;
    return (hi < CRD_MAX) ? hi + 1 : hi;
  endfunction

  function automatic bcn_in_t noise_item();
    return mk_in(2'($urandom_range(0, 3)), $urandom_range(CRD_MAX, 0),
                 $urandom_range(CRD_MAX, 0), $urandom_range(CRD_MAX, 0), 1'($urandom));
  endfunction

  // One crop pass: usually a begin, then measure a cluster, finish, normalise a batch
  task automatic run_crop_pass();
    int base [3];
    int span [3];
    int n_meas;
    int n_norm;
    int sel;
    for (int a = 0; a < 3; a++) begin
      base[a] = $urandom_range(UNIT, 0);
      sel     = $urandom_range(0, 99);
      if (sel < 12)      span[a] = 0;
      else if (sel < 30) span[a] = $urandom_range(16, 1);
      else if (sel < 70) span[a] = $urandom_range(4096, 17);
      else               span[a] = $urandom_range(UNIT, 4097);
    end
    sel = $urandom_range(0, 99);
    if (sel < 10)      n_meas = 0;
    else if (sel < 80) n_meas = $urandom_range(1, 6);
    else               n_meas = $urandom_range(7, 20);
    n_norm = $urandom_range(1, 10);

    if ($urandom_range(0, 99) < 92)
      send_plain(mk_in(REQ_BEGIN, any_coord(), any_coord(), any_coord(), 1'($urandom)));
    for (int k = 0; k < n_meas; k++) begin
      if ($urandom_range(0, 99) < 6) send_plain(noise_item());
      else send_plain(mk_in(REQ_MEASURE, window_coord(base[0], span[0]),
                            window_coord(base[1], span[1]), window_coord(base[2], span[2]),
                            $urandom_range(0, 99) < 85));
    end
    send_plain(mk_in(REQ_FINISH, any_coord(), any_coord(), any_coord(), 1'($urandom)));
    for (int k = 0; k < n_norm; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 5)
        send_plain(noise_item());
      else if (sel < 11)
        // widen the bounds after the extents were latched
        send_plain(mk_in(REQ_MEASURE, window_coord(base[0], span[0]),
                         window_coord(base[1], span[1]), window_coord(base[2], span[2]), 1'b1));
      else
        send_plain(mk_in(REQ_NORM, norm_coord(0), norm_coord(1), norm_coord(2),
                         $urandom_range(0, 99) < 80));
    end
  endtask

  // Receiver stall pattern: free-running, random, periodic or mostly stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 400);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 35);
        2:       out_stall <= ((stall_tick % 5) < 2);
        default: out_stall <= ($urandom_range(0, 19) != 0);
      endcase
    end
  end

  // Compare every result transfer with the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (crop_results_due.size() == 0) begin
        report_mismatch("result with nothing owed", out_data.norm_x, 0);
      end else begin
        want_res = crop_results_due.pop_front();
        results_checked++;
        if (out_data.norm_x !== want_res.norm_x)
          report_mismatch("norm_x", out_data.norm_x, want_res.norm_x);
        if (out_data.norm_y !== want_res.norm_y)
          report_mismatch("norm_y", out_data.norm_y, want_res.norm_y);
        if (out_data.norm_z !== want_res.norm_z)
          report_mismatch("norm_z", out_data.norm_z, want_res.norm_z);
        if (out_data.scaled_a !== want_res.scaled_a)
          report_mismatch("scaled_a", out_data.scaled_a, want_res.scaled_a);
        if (out_data.scaled_b !== want_res.scaled_b)
          report_mismatch("scaled_b", out_data.scaled_b, want_res.scaled_b);
        if (out_data.scaled_c !== want_res.scaled_c)
          report_mismatch("scaled_c", out_data.scaled_c, want_res.scaled_c);
        if (out_data.degenerate !== want_res.degenerate)
          report_mismatch("degenerate", out_data.degenerate, want_res.degenerate);
        if (out_data.empty_set !== want_res.empty_set)
          report_mismatch("empty_set", out_data.empty_set, want_res.empty_set);
      end
    end
  end

  // Main sequence
  initial begin
    int pass_cnt;
    int dir_work;
    int drain;

    for (int a = 0; a < 3; a++) begin
      bnd_min[a]  = CRD_W'(UNIT);
      bnd_max[a]  = '0;
      ext_lat[a]  = '0;
      cell_len[a] = LEN_BITS'(UNIT);
    end
    seen_atom  = 1'b0;
    burst_left = $urandom_range(1, 12);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed rows are values that follow directly from reset or extremes
    dir_rows.push_back('{mk_in(REQ_NORM, 'h8000, 0, UNIT, 1'b1), 1'b1,
                         mk_res(0, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
    dir_rows.push_back('{mk_in(REQ_NORM, CRD_MAX, 'h12345, 1, 1'b0), 1'b1,
                         mk_res(UNIT, UNIT, 1, 0, 0, 0, 1'b1, 1'b0)});
    dir_rows.push_back('{mk_in(REQ_FINISH, 0, 0, 0, 1'b0), 1'b1,
                         mk_res(0, 0, 0, UNIT, UNIT, UNIT, 1'b1, 1'b1)});
    dir_rows.push_back('{mk_in(REQ_MEASURE, CRD_MAX, 0, 'h4000, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_FINISH, CRD_MAX, CRD_MAX, CRD_MAX, 1'b1), 1'b1,
                         mk_res(0, 0, 0, UNIT, UNIT, UNIT, 1'b1, 1'b1)});
    dir_rows.push_back('{mk_in(REQ_BEGIN, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_MEASURE, 'h4000, 0, CRD_MAX, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_MEASURE, 'hC000, CRD_MAX, 'h8000, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_MEASURE, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_FINISH, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_NORM, 'h4000, 0, 'h8000, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_NORM, 'h3000, CRD_MAX, CRD_MAX, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_NORM, 'h6000, 'h5555, 'hAAAA, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_NORM, 'h6000, 'h5555, 'h1AAAA, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_MEASURE, 'h1000, 'h8000, 'h8000, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_NORM, 'h1000, 'h8000, 'hFFFF, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_NORM, 'hF000, 'h0001, UNIT, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_BEGIN, CRD_MAX, CRD_MAX, CRD_MAX, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_MEASURE, 'h7777, 'h7777, 'h7777, 1'b1), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_FINISH, 0, 0, 0, 1'b1), 1'b1,
                         mk_res(0, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
    dir_rows.push_back('{mk_in(REQ_NORM, 'h7777, 'h8000, 0, 1'b1), 1'b1,
                         mk_res(0, 0, 0, 0, 0, 0, 1'b1, 1'b0)});
    dir_rows.push_back('{mk_in(REQ_BEGIN, 0, 0, 0, 1'b0), 1'b0, '0});
    dir_rows.push_back('{mk_in(REQ_FINISH, 0, 0, 0, 1'b0), 1'b1,
                         mk_res(0, 0, 0, UNIT, UNIT, UNIT, 1'b1, 1'b1)});

    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    dir_work = work_items;

    // Random crop passes, with the cell lengths changed every third pass
    pass_cnt = 0;
    while (work_items - dir_work < RAND_ITEMS) begin
      if (pass_cnt % 3 == 0) begin
        settle_idle();
        case (len_settings)
          0:       program_lengths('1, '1, '1);
          1:       program_lengths('0, '0, '0);
          2:       program_lengths(LEN_BITS'(1), {1'b1, {(LEN_BITS-1){1'b0}}}, LEN_BITS'(UNIT));
          default: program_lengths(pick_length(), pick_length(), pick_length());
        endcase
      end
      run_crop_pass();
      pass_cnt++;
    end

    // Drain owed results, then a settling window
    in_valid <= 1'b0;
    drain = 0;
    while (crop_results_due.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (crop_results_due.size() != 0)
      report_mismatch("results never delivered", crop_results_due.size(), 0);

    $display("Covered %0d directed rows and %0d random items in %0d crop passes",
             dir_rows.size(), work_items - dir_work, pass_cnt);
    $display("Checked %0d results (%0d finishes, %0d normalise requests), %0d length settings",
             results_checked, finishes_sent, norms_sent, len_settings);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
